// File: rtl/assert_macros.svh
// Assertion macros shared by the midrange threshold binarizer RTL.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/mtb_pkg.sv
// Types and constants of the midrange threshold binarizer.
// No dependencies; imported by every RTL module of the block.
`default_nettype none

package mtb_pkg;

    localparam int PIX_W       = 8;
    localparam int LUMA_ACC_W  = 24;
    localparam int LUMA_SHIFT  = 16;
    localparam int QUEUE_DEPTH_DEF = 2;

    typedef logic [PIX_W-1:0]      pix_t;
    typedef logic [LUMA_ACC_W-1:0] luma_acc_t;

    // Q0.16 weights for 0.21, 0.72, 0.07
    localparam luma_acc_t LUMA_WR = luma_acc_t'(13763);
    localparam luma_acc_t LUMA_WG = luma_acc_t'(47186);
    localparam luma_acc_t LUMA_WB = luma_acc_t'(4588);

    localparam logic MODE_MEASURE  = 1'b0;
    localparam logic MODE_BINARIZE = 1'b1;

    localparam logic COLOR_GRAY = 1'b0;
    localparam logic COLOR_RGB  = 1'b1;

    localparam pix_t MIN_RESET  = 8'd255;
    localparam pix_t MAX_RESET  = 8'd0;
    localparam pix_t LEVEL_HIGH = 8'd255;
    localparam pix_t LEVEL_LOW  = 8'd0;

    typedef struct packed {
        logic mode;
        logic frame_start;
        pix_t intensity;
    } item_t;

endpackage

`default_nettype wire

// File: rtl/mtb_front.sv
// Front end: accepts pixel items and reduces them to an intensity.
// Depends on mtb_pkg; feeds the item queue.
`default_nettype none

module mtb_front (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           color_mode,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire logic           s_mode,
    input  wire logic           s_frame_start,
    input  wire mtb_pkg::pix_t  s_red,
    input  wire mtb_pkg::pix_t  s_green,
    input  wire mtb_pkg::pix_t  s_blue,
    output logic                q_valid,
    input  wire logic           q_ready,
    output mtb_pkg::item_t      q_item
);
    import mtb_pkg::*;

    logic      valid_reg, valid_next;
    logic      mode_reg;
    logic      fs_reg;
    logic      rgb_reg;
    pix_t      gray_reg;
    luma_acc_t prod_r_reg, prod_g_reg, prod_b_reg;
    luma_acc_t luma_sum;
    logic      take;

    assign s_ready = !valid_reg || q_ready;
    assign take    = s_valid && s_ready;

    always_comb begin
        valid_next = valid_reg;
        if (take) begin
            valid_next = 1'b1;
        end else if (q_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            mode_reg   <= s_mode;
            fs_reg     <= s_frame_start;
            rgb_reg    <= (color_mode == COLOR_RGB);
            gray_reg   <= s_red;
            prod_r_reg <= luma_acc_t'(s_red) * LUMA_WR;
            prod_g_reg <= luma_acc_t'(s_green) * LUMA_WG;
            prod_b_reg <= luma_acc_t'(s_blue) * LUMA_WB;
        end
    end

    assign luma_sum = prod_r_reg + prod_g_reg + prod_b_reg;

    assign q_valid              = valid_reg;
    assign q_item.mode          = mode_reg;
    assign q_item.frame_start   = fs_reg;
    assign q_item.intensity     = rgb_reg ? luma_sum[LUMA_SHIFT +: PIX_W] : gray_reg;

endmodule

`default_nettype wire

// File: rtl/mtb_queue.sv
// Small item queue between the front end and the back end.
// Depends on mtb_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module mtb_queue #(
    parameter int DEPTH = mtb_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire mtb_pkg::item_t  in_item,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output mtb_pkg::item_t       out_item
);
    import mtb_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    item_t           mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            push, pop;

    assign in_ready  = (count_reg != CW'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    `ASSERT_IMPL(a_queue_count_bound, aclk, aresetn, 1'b1, count_reg <= CW'(DEPTH))
    `ASSERT_NEXT(a_queue_push_grows, aclk, aresetn, push && !pop, count_reg == $past(count_reg) + CW'(1))

endmodule

`default_nettype wire

// File: rtl/mtb_back.sv
// Back end: keeps the running min/max and binarizes against the midrange.
// Depends on mtb_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module mtb_back (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            q_valid,
    output logic                 q_ready,
    input  wire mtb_pkg::item_t  q_item,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output mtb_pkg::pix_t        m_level,
    output mtb_pkg::pix_t        m_threshold_used
);
    import mtb_pkg::*;

    pix_t             min_reg, min_next;
    pix_t             max_reg, max_next;
    logic             valid_reg, valid_next;
    pix_t             level_reg;
    pix_t             thr_reg;
    pix_t             min_base, max_base;
    logic [PIX_W:0]   mid_sum;
    pix_t             thr;
    logic             pop, is_measure, emit;

    assign is_measure = (q_item.mode == MODE_MEASURE);
    assign q_ready    = is_measure || !valid_reg || m_ready;
    assign pop        = q_valid && q_ready;
    assign emit       = pop && !is_measure;

    assign mid_sum = {1'b0, min_reg} + {1'b0, max_reg};
    assign thr     = mid_sum[PIX_W:1];

    always_comb begin
        min_base = q_item.frame_start ? MIN_RESET : min_reg;
        max_base = q_item.frame_start ? MAX_RESET : max_reg;
        min_next = min_reg;
        max_next = max_reg;
        if (pop && is_measure) begin
            min_next = (q_item.intensity < min_base) ? q_item.intensity : min_base;
            max_next = (q_item.intensity > max_base) ? q_item.intensity : max_base;
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (emit) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg   <= MIN_RESET;
            max_reg   <= MAX_RESET;
            valid_reg <= 1'b0;
        end else begin
            min_reg   <= min_next;
            max_reg   <= max_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            level_reg <= (q_item.intensity > thr) ? LEVEL_HIGH : LEVEL_LOW;
            thr_reg   <= thr;
        end
    end

    assign m_valid          = valid_reg;
    assign m_level          = level_reg;
    assign m_threshold_used = thr_reg;

    `ASSERT_NEXT(a_back_measure_silent, aclk, aresetn, pop && is_measure && !valid_reg, !valid_reg)
    `ASSERT_NEXT(a_back_min_le_max, aclk, aresetn, pop && is_measure, min_reg <= max_reg)

endmodule

`default_nettype wire

// File: rtl/midrange_threshold_binarizer_top.sv
// Top level of the midrange threshold binarizer.
// Depends on mtb_pkg, mtb_front, mtb_queue and mtb_back.
//
// Usage:
//   The image is streamed twice on the s_ channel (valid/ready). Items with
//   s_mode = measure update the running min/max of the pixel intensity and
//   give no result; s_frame_start on a measure item clears min/max first.
//   Items with s_mode = binarize each give one m_ channel result: m_level is
//   255 when the intensity is above (min+max)/2, else 0, with the threshold
//   on m_threshold_used. cfg_valid/cfg_data write color_mode (0 gray in the
//   red field, 1 RGB luma); write it only while the block is idle.
//   Path: a binarize item passes the product register, the queue and the
//   output register before m_valid rises; a stall can hold it in any of them.
//   Throughput: one item per clock while m_ready is high; the back end updates
//   min/max or compares each item as it takes it.
//   Reset (aresetn low, synchronous) empties the pipeline and queue, sets
//   min to 255, max to 0 (threshold 127) and color_mode to gray.
//   When the receiver holds m_ready low, the result is held, measure items
//   keep draining, and the queue absorbs items until the input stalls.
`default_nettype none

module midrange_threshold_binarizer_top #(
    parameter int QUEUE_DEPTH = mtb_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           cfg_valid,
    output logic                cfg_ready,
    input  wire logic           cfg_data,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire logic           s_mode,
    input  wire logic           s_frame_start,
    input  wire mtb_pkg::pix_t  s_red,
    input  wire mtb_pkg::pix_t  s_green,
    input  wire mtb_pkg::pix_t  s_blue,
    output logic                m_valid,
    input  wire logic           m_ready,
    output mtb_pkg::pix_t       m_level,
    output mtb_pkg::pix_t       m_threshold_used
);
    import mtb_pkg::*;

    logic  color_mode_reg;
    logic  fq_valid, fq_ready;
    item_t fq_item;
    logic  qb_valid, qb_ready;
    item_t qb_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_mode_reg <= COLOR_GRAY;
        end else if (cfg_valid && cfg_ready) begin
            color_mode_reg <= cfg_data;
        end
    end

    mtb_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .color_mode    (color_mode_reg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_mode        (s_mode),
        .s_frame_start (s_frame_start),
        .s_red         (s_red),
        .s_green       (s_green),
        .s_blue        (s_blue),
        .q_valid       (fq_valid),
        .q_ready       (fq_ready),
        .q_item        (fq_item)
    );

    mtb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_item   (fq_item),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_item  (qb_item)
    );

    mtb_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_valid          (qb_valid),
        .q_ready          (qb_ready),
        .q_item           (qb_item),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_level          (m_level),
        .m_threshold_used (m_threshold_used)
    );

endmodule

`default_nettype wire

// File: bench/midrange_threshold_binarizer_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for midrange_threshold_binarizer_top: streams measure and
// binarize passes over random images in gray and RGB color modes, with random gaps.
// Depends on mtb_pkg and the block's RTL; expected results come from a scoreboard class.

module midrange_threshold_binarizer_top_tb;
    import mtb_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int RANDOM_ITEMS   = 850;
    localparam int PHASE_ITEMS    = 110;

    typedef struct packed {
        pix_t level;
        pix_t thr;
    } result_t;

    class threshold_scoreboard;
        logic      color_rgb;
        pix_t      lo;
        pix_t      hi;
        result_t   expected_q[$];
        int        errors;

        function new();
            color_rgb = COLOR_GRAY;
            lo        = MIN_RESET;
            hi        = MAX_RESET;
            errors    = 0;
        endfunction

        function pix_t intensity(pix_t r, pix_t g, pix_t b);
            logic [31:0] acc;
            if (color_rgb == COLOR_GRAY) begin
                return r;
            end
            acc = 32'(LUMA_WR) * 32'(r) + 32'(LUMA_WG) * 32'(g) + 32'(LUMA_WB) * 32'(b);
            acc = acc >> LUMA_SHIFT;
            return (acc > 32'd255) ? 8'd255 : acc[7:0];
        endfunction

        function void note_pixel(logic mode, logic fs, pix_t r, pix_t g, pix_t b);
            pix_t        y;
            logic [8:0]  sum;
            result_t     res;
            y = intensity(r, g, b);
            if (mode == MODE_MEASURE) begin
                if (fs) begin
                    lo = MIN_RESET;
                    hi = MAX_RESET;
                end
                if (y < lo) lo = y;
                if (y > hi) hi = y;
            end else begin
                sum       = {1'b0, lo} + {1'b0, hi};
                res.thr   = sum[8:1];
                res.level = (y > res.thr) ? LEVEL_HIGH : LEVEL_LOW;
                expected_q.push_back(res);
            end
        endfunction

        function void report(string what, int exp_val, int act_val);
            errors++;
            if (errors <= 10) begin
                $display("%0t: mismatch on %s: expected %0d, actual %0d",
                         $realtime, what, exp_val, act_val);
            end
        endfunction

        function void check_result(pix_t level, pix_t thr);
            result_t exp_res;
            if (expected_q.size() == 0) begin
                report("unexpected result (level)", -1, level);
                return;
            end
            exp_res = expected_q.pop_front();
            if (level !== exp_res.level) report("m_level", exp_res.level, level);
            if (thr !== exp_res.thr) report("m_threshold_used", exp_res.thr, thr);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic aclk          = 1'b0;
    logic aresetn       = 1'b0;
    logic cfg_valid     = 1'b0;
    logic cfg_data      = 1'b0;
    logic s_valid       = 1'b0;
    logic s_mode        = 1'b0;
    logic s_frame_start = 1'b0;
    pix_t s_red         = '0;
    pix_t s_green       = '0;
    pix_t s_blue        = '0;
    logic m_ready       = 1'b0;
    logic cfg_ready;
    logic s_ready;
    logic m_valid;
    pix_t m_level;
    pix_t m_threshold_used;

    threshold_scoreboard sb = new();
    bit calm = 1'b0;
    int n_sent = 0;
    int idle_cycles = 0;

    midrange_threshold_binarizer_top u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_mode           (s_mode),
        .s_frame_start    (s_frame_start),
        .s_red            (s_red),
        .s_green          (s_green),
        .s_blue           (s_blue),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_level          (m_level),
        .m_threshold_used (m_threshold_used)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int pick_gap();
        int p;
        if (calm) return 0;
        p = $urandom_range(99);
        if (p < 65) return 0;
        if (p < 88) return $urandom_range(1, 3);
        if (p < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic pix_t rand_pix();
        case ($urandom_range(9))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // called at a falling edge, returns at a falling edge after the item is taken
    task automatic send_pixel(logic mode, logic fs, pix_t r, pix_t g, pix_t b);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid       = 1'b1;
        s_mode        = mode;
        s_frame_start = fs;
        s_red         = r;
        s_green       = g;
        s_blue        = b;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        n_sent++;
    endtask

    task automatic drain();
        s_valid = 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic settle();
        s_valid = 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_color(logic c);
        settle();
        cfg_valid = 1'b1;
        cfg_data  = c;
        do @(posedge aclk); while (!cfg_ready);
        sb.color_rgb = c;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic run_frame(int npix, bit pause);
        pix_t pr[64];
        pix_t pg[64];
        pix_t pb[64];
        int   i;
        logic fs;
        for (i = 0; i < npix; i++) begin
            pr[i] = rand_pix();
            pg[i] = rand_pix();
            pb[i] = rand_pix();
        end
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 6)) begin
                send_pixel(1'($urandom_range(1)), 1'($urandom_range(1)),
                           rand_pix(), rand_pix(), rand_pix());
            end
        end
        for (i = 0; i < npix; i++) begin
            fs = (i == 0) ? ($urandom_range(9) != 0) : ($urandom_range(24) == 0);
            send_pixel(MODE_MEASURE, fs, pr[i], pg[i], pb[i]);
        end
        if (pause) drain();
        for (i = 0; i < npix; i++) begin
            if ($urandom_range(19) == 0) begin
                send_pixel(MODE_BINARIZE, 1'($urandom_range(1)),
                           rand_pix(), rand_pix(), rand_pix());
            end else begin
                send_pixel(MODE_BINARIZE, $urandom_range(7) == 0, pr[i], pg[i], pb[i]);
            end
        end
    endtask

    initial begin : receiver
        int hold;
        hold = 0;
        forever begin
            @(negedge aclk);
            if (hold > 0) begin
                m_ready = 1'b0;
                hold--;
            end else begin
                m_ready = 1'b1;
                hold    = pick_gap();
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.note_pixel(s_mode, s_frame_start, s_red, s_green, s_blue);
            end
            if (m_valid && m_ready) begin
                sb.check_result(m_level, m_threshold_used);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("midrange_threshold_binarizer_top_tb: done, errors");
                $finish;
            end
        end
    end

    initial begin : stimulus
        int  phase;
        int  phase_end;
        int  target;
        bit  first_frame;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // gray: nothing measured yet, threshold from reset values
        write_color(COLOR_GRAY);
        send_pixel(MODE_BINARIZE, 1'b0, 8'd127, 8'd255, 8'd255);
        send_pixel(MODE_BINARIZE, 1'b1, 8'd128, 8'hAA, 8'h55);
        send_pixel(MODE_BINARIZE, 1'b0, 8'd0, 8'd0, 8'd0);
        send_pixel(MODE_BINARIZE, 1'b0, 8'd255, 8'd0, 8'd0);
        send_pixel(MODE_MEASURE, 1'b1, 8'd10, 8'hFF, 8'h00);
        send_pixel(MODE_MEASURE, 1'b0, 8'd200, 8'h00, 8'hFF);
        send_pixel(MODE_BINARIZE, 1'b1, 8'd105, 8'd0, 8'd0);
        send_pixel(MODE_BINARIZE, 1'b0, 8'd106, 8'd0, 8'd0);
        send_pixel(MODE_MEASURE, 1'b1, 8'd255, 8'd0, 8'd0);
        send_pixel(MODE_BINARIZE, 1'b0, 8'd255, 8'd0, 8'd0);
        send_pixel(MODE_MEASURE, 1'b1, 8'd0, 8'd255, 8'd255);
        send_pixel(MODE_BINARIZE, 1'b0, 8'd0, 8'd0, 8'd0);
        send_pixel(MODE_BINARIZE, 1'b0, 8'd1, 8'd0, 8'd0);

        // RGB luma extremes
        write_color(COLOR_RGB);
        send_pixel(MODE_MEASURE, 1'b1, 8'd255, 8'd255, 8'd255);
        send_pixel(MODE_MEASURE, 1'b0, 8'd0, 8'd0, 8'd0);
        send_pixel(MODE_BINARIZE, 1'b0, 8'd255, 8'd0, 8'd0);
        send_pixel(MODE_BINARIZE, 1'b0, 8'd0, 8'd255, 8'd0);
        send_pixel(MODE_BINARIZE, 1'b0, 8'd0, 8'd0, 8'd255);
        send_pixel(MODE_BINARIZE, 1'b0, 8'd128, 8'd128, 8'd128);
        send_pixel(MODE_BINARIZE, 1'b0, 8'd127, 8'd127, 8'd127);

        target      = n_sent + RANDOM_ITEMS;
        phase       = 0;
        first_frame = 1'b1;
        while (n_sent < target) begin
            write_color((phase < 2) ? 1'(phase) : 1'($urandom_range(1)));
            calm      = (phase % 3 == 2);
            phase_end = n_sent + PHASE_ITEMS;
            while (n_sent < phase_end) begin
                run_frame(($urandom_range(19) == 0) ? 48 : $urandom_range(1, 16),
                          first_frame || ($urandom_range(9) == 0));
                first_frame = 1'b0;
            end
            phase++;
        end

        calm = 1'b0;
        s_valid = 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("midrange_threshold_binarizer_top_tb: done, clean");
        end else begin
            $display("midrange_threshold_binarizer_top_tb: done, errors");
        end
        $finish;
    end

endmodule
